[src/scr_pkg.sv]
// Shared types, character codes and classification functions of the script tokenizer.
`timescale 1ns / 1ps
package scr_pkg;

    // Longest token that is kept; further characters of the same token are dropped.
    localparam logic [9:0] MAX_TOKEN_CHARS = 10'd1022;

    // Bundle queue between the front and back parts; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Most results that one request can cause.
    localparam int MAX_RESULTS = 3;

    // Input kinds.
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Character codes.
    localparam logic [15:0] CH_TAB    = 16'h0009;
    localparam logic [15:0] CH_LF     = 16'h000A;
    localparam logic [15:0] CH_CR     = 16'h000D;
    localparam logic [15:0] CH_SPACE  = 16'h0020;
    localparam logic [15:0] CH_QUOTE  = 16'h0022;
    localparam logic [15:0] CH_LPAREN = 16'h0028;
    localparam logic [15:0] CH_RPAREN = 16'h0029;
    localparam logic [15:0] CH_STAR   = 16'h002A;
    localparam logic [15:0] CH_PLUS   = 16'h002B;
    localparam logic [15:0] CH_MINUS  = 16'h002D;
    localparam logic [15:0] CH_SLASH  = 16'h002F;
    localparam logic [15:0] CH_ZERO   = 16'h0030;
    localparam logic [15:0] CH_NINE   = 16'h0039;
    localparam logic [15:0] CH_EQUAL  = 16'h003D;
    localparam logic [15:0] CH_LBRACK = 16'h005B;
    localparam logic [15:0] CH_RBRACK = 16'h005D;
    localparam logic [15:0] CH_LBRACE = 16'h007B;
    localparam logic [15:0] CH_RBRACE = 16'h007D;

    typedef struct packed {
        logic        kind;
        logic [15:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic        has_char;
        logic [15:0] char_value;
        logic        token_end;
        logic        last_of_run;
    } t_out_item;

    // One result as the front part builds it; the run marker is added on the way out.
    typedef struct packed {
        logic        has_char;
        logic [15:0] char_value;
        logic        token_end;
    } t_slot;

    // All results of one request, oldest in slot 0.
    typedef struct packed {
        logic [1:0]                  cnt;
        t_slot [MAX_RESULTS-1:0]     slot;
    } t_bundle;

    function automatic logic is_separator(input logic [15:0] c);
        logic r;
        case (c) inside
            CH_SPACE, CH_TAB, CH_CR, CH_LF: r = 1'b1;
            default:                        r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_operator(input logic [15:0] c);
        logic r;
        case (c) inside
            CH_EQUAL, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
            CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
            CH_LPAREN, CH_RPAREN: r = 1'b1;
            default:              r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_digit(input logic [15:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Appends one result to a bundle.
    function automatic t_bundle add_result(input t_bundle b, input logic has,
                                           input logic [15:0] val, input logic fin);
        t_bundle r;
        r = b;
        if (b.cnt < 2'(MAX_RESULTS)) begin
            r.slot[b.cnt].has_char   = has;
            r.slot[b.cnt].char_value = has ? val : 16'h0000;
            r.slot[b.cnt].token_end  = fin;
            r.cnt                    = b.cnt + 2'd1;
        end
        return r;
    endfunction

endpackage

[src/script_tokenizer.sv]
// Top level of the script tokenizer: front part, bundle queue and back part.
`timescale 1ns / 1ps
// The script tokenizer takes a text one 16-bit character per request and gives
// back a stream of token characters and token-end marks. Space, tab, CR and LF
// separate tokens; each of the operators = + - * / { } [ ] ( ) is a token of
// its own, and a minus directly before a digit stays inside the word. A double
// quote opens a run that continues the current token up to the closing quote,
// which ends it. A request of kind end-of-text closes whatever is still open
// (an open quote, a held minus, a non-empty token) and returns the block to
// its reset state. Characters beyond 1022 in one token are dropped. One
// request causes between zero and three results; the last of them carries
// last_of_run. Requests are taken one per cycle for as long as full is low:
// the front part decides all results of a request in the cycle it is taken and
// writes them as one bundle into a four-entry queue. The first result of a
// request can be on o_result from the cycle after it is taken. The back
// part hands out one result per pop, so a request with three results holds the
// output for three pops; full rises only when four bundles wait behind a
// stalled consumer. Requests that cause no result never enter the queue.
module script_tokenizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  scr_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output scr_pkg::t_out_item o_result
);
    import scr_pkg::*;

    logic    accept;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    t_bundle front_bundle;
    t_bundle head_bundle;

    // A request is taken whenever the queue has room for its bundle.
    assign accept = push && !q_full;
    assign full   = q_full;

    scr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_bundle (front_bundle),
        .o_push   (q_push)
    );

    scr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_bundle),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (head_bundle),
        .o_empty (q_empty)
    );

    // The back part drains the head bundle and frees it after its last result.
    scr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_bundle),
        .i_head_empty (q_empty),
        .o_head_pop   (q_pop),
        .o_result     (o_result),
        .empty        (empty),
        .pop          (pop)
    );

endmodule

[src/scr_front.sv]
// Front part: holds the tokenizer state and turns each request into a bundle of results.
`timescale 1ns / 1ps
module scr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  scr_pkg::t_in_item i_item,
    output scr_pkg::t_bundle  o_bundle,
    output logic              o_push
);
    import scr_pkg::*;

    logic       r_in_quote;
    logic       r_pending_minus;
    logic [9:0] r_token_length;
    logic       n_in_quote;
    logic       n_pending_minus;
    logic [9:0] n_token_length;
    t_bundle    b;
    logic       done;
    logic [15:0] c;

    always_comb begin
        b               = '0;
        done            = 1'b0;
        c               = i_item.char_code;
        n_in_quote      = r_in_quote;
        n_pending_minus = r_pending_minus;
        n_token_length  = r_token_length;
        if (i_item.kind == KIND_END) begin
            if (r_in_quote) begin
                b = add_result(b, 1'b0, 16'h0000, 1'b1);
            end else if (r_pending_minus) begin
                if (r_token_length != 10'd0) begin
                    b = add_result(b, 1'b0, 16'h0000, 1'b1);
                end
                b = add_result(b, 1'b1, CH_MINUS, 1'b1);
            end else if (r_token_length != 10'd0) begin
                b = add_result(b, 1'b0, 16'h0000, 1'b1);
            end
            n_in_quote      = 1'b0;
            n_pending_minus = 1'b0;
            n_token_length  = 10'd0;
        end else if (r_in_quote) begin
            if (c == CH_QUOTE) begin
                n_in_quote     = 1'b0;
                n_token_length = 10'd0;
                b = add_result(b, 1'b0, 16'h0000, 1'b1);
            end else if (n_token_length < MAX_TOKEN_CHARS) begin
                n_token_length = n_token_length + 10'd1;
                b = add_result(b, 1'b1, c, 1'b0);
            end
        end else begin
            if (r_pending_minus) begin
                n_pending_minus = 1'b0;
                if (is_digit(c)) begin
                    // The held minus joins the number, both subject to the length cap.
                    done = 1'b1;
                    if (n_token_length < MAX_TOKEN_CHARS) begin
                        n_token_length = n_token_length + 10'd1;
                        b = add_result(b, 1'b1, CH_MINUS, 1'b0);
                    end
                    if (n_token_length < MAX_TOKEN_CHARS) begin
                        n_token_length = n_token_length + 10'd1;
                        b = add_result(b, 1'b1, c, 1'b0);
                    end
                end else begin
                    if (n_token_length != 10'd0) begin
                        b = add_result(b, 1'b0, 16'h0000, 1'b1);
                    end
                    b = add_result(b, 1'b1, CH_MINUS, 1'b1);
                    n_token_length = 10'd0;
                end
            end
            if (!done) begin
                if (c == CH_QUOTE) begin
                    n_in_quote = 1'b1;
                end else if (is_separator(c)) begin
                    if (n_token_length != 10'd0) begin
                        b = add_result(b, 1'b0, 16'h0000, 1'b1);
                        n_token_length = 10'd0;
                    end
                end else if (c == CH_MINUS) begin
                    n_pending_minus = 1'b1;
                end else if (is_operator(c)) begin
                    if (n_token_length != 10'd0) begin
                        b = add_result(b, 1'b0, 16'h0000, 1'b1);
                    end
                    b = add_result(b, 1'b1, c, 1'b1);
                    n_token_length = 10'd0;
                end else if (n_token_length < MAX_TOKEN_CHARS) begin
                    n_token_length = n_token_length + 10'd1;
                    b = add_result(b, 1'b1, c, 1'b0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quote      <= 1'b0;
            r_pending_minus <= 1'b0;
            r_token_length  <= 10'd0;
        end else if (i_accept) begin
            r_in_quote      <= n_in_quote;
            r_pending_minus <= n_pending_minus;
            r_token_length  <= n_token_length;
        end
    end

    assign o_bundle = b;
    assign o_push   = i_accept && (b.cnt != 2'd0);

    // End of text leaves the state as after reset.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.kind == KIND_END) |=>
            (!r_in_quote && !r_pending_minus && r_token_length == 10'd0))
        else $error("state not cleared after end of text");

    // A minus is only ever held outside quotes.
    a_minus_outside_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_quote && r_pending_minus))
        else $error("held minus inside a quoted run");

    // The kept length never passes the cap.
    a_length_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_token_length <= MAX_TOKEN_CHARS)
        else $error("token length above the cap");

endmodule

[src/scr_queue.sv]
// Short queue of result bundles between the front and back parts.
`timescale 1ns / 1ps
module scr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  scr_pkg::t_bundle i_data,
    output logic             o_full,
    input  logic             i_pop,
    output scr_pkg::t_bundle o_data,
    output logic             o_empty
);
    import scr_pkg::*;

    t_bundle                r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QUEUE_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QUEUE_CNT_W'(1);
            end
        end
    end

    assign o_data  = r_entry[r_rd_ptr];
    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("bundle written into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("bundle taken from an empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

[src/scr_back.sv]
// Back part: hands out the results of the oldest bundle one at a time.
`timescale 1ns / 1ps
module scr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scr_pkg::t_bundle   i_head,
    input  logic               i_head_empty,
    output logic               o_head_pop,
    output scr_pkg::t_out_item o_result,
    output logic               empty,
    input  logic               pop
);
    import scr_pkg::*;

    logic [1:0] r_idx;
    t_slot      cur;
    logic       last;
    logic       take;

    assign cur  = i_head.slot[r_idx];
    assign last = (r_idx == (i_head.cnt - 2'd1));
    assign take = pop && !i_head_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (take) begin
            r_idx <= last ? 2'd0 : r_idx + 2'd1;
        end
    end

    assign o_result.has_char    = cur.has_char;
    assign o_result.char_value  = cur.char_value;
    assign o_result.token_end   = cur.token_end;
    assign o_result.last_of_run = last;
    assign empty                = i_head_empty;
    assign o_head_pop           = take && last;

    a_bundle_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_empty |-> (i_head.cnt != 2'd0))
        else $error("empty bundle in the queue");

    a_index_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_empty |-> (r_idx < i_head.cnt))
        else $error("result index beyond the bundle");

    a_index_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_empty |-> (r_idx == 2'd0))
        else $error("result index left over with no bundle waiting");

endmodule

[sim/tb_script_tokenizer.sv]
// Self-checking testbench of the script tokenizer with a token predictor and a result scoreboard.
`timescale 1ns / 1ps
module tb_script_tokenizer;
    import scr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 150;
    localparam int RANDOM_REQS = 110;

    localparam logic [15:0] OPS [11] = '{CH_EQUAL, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                         CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                                         CH_LPAREN, CH_RPAREN};
    localparam logic [15:0] SEPS [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

    // Predicts the token stream and holds the results still owed by the block.
    class token_stream_board;
        t_out_item  owed_results[$];
        t_out_item  run[$];
        int         errors;
        bit         quoted;
        bit         minus_held;
        logic [9:0] kept_len;

        function new();
            errors     = 0;
            quoted     = 1'b0;
            minus_held = 1'b0;
            kept_len   = '0;
        endfunction

        function bit splits_tokens(input logic [15:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
        endfunction

        function bit stands_alone(input logic [15:0] c);
            foreach (OPS[i]) begin
                if (c == OPS[i]) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void emit(input bit has, input logic [15:0] val, input bit fin);
            if (run.size() < MAX_RESULTS) begin
                run.push_back('{has_char: has, char_value: has ? val : 16'h0000,
                                token_end: fin, last_of_run: 1'b0});
            end
        endfunction

        // Characters past the length limit vanish without a result.
        function void keep_char(input logic [15:0] c);
            if (kept_len < MAX_TOKEN_CHARS) begin
                kept_len = kept_len + 10'd1;
                emit(1'b1, c, 1'b0);
            end
        endfunction

        function void close_current();
            kept_len = '0;
            emit(1'b0, 16'h0000, 1'b1);
        endfunction

        function void lone_token(input logic [15:0] c);
            if (kept_len != 0) close_current();
            emit(1'b1, c, 1'b1);
            kept_len = '0;
        endfunction

        function void take_text(input logic [15:0] c);
            if (quoted) begin
                if (c == CH_QUOTE) begin
                    quoted = 1'b0;
                    close_current();
                end else begin
                    keep_char(c);
                end
                return;
            end
            // A held minus joins a following digit, otherwise it becomes its own token.
            if (minus_held) begin
                minus_held = 1'b0;
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    keep_char(CH_MINUS);
                    keep_char(c);
                    return;
                end
                lone_token(CH_MINUS);
            end
            if (c == CH_QUOTE) begin
                quoted = 1'b1;
            end else if (splits_tokens(c)) begin
                if (kept_len != 0) close_current();
            end else if (c == CH_MINUS) begin
                minus_held = 1'b1;
            end else if (stands_alone(c)) begin
                lone_token(c);
            end else begin
                keep_char(c);
            end
        endfunction

        function void note_request(input t_in_item req);
            run.delete();
            if (req.kind == KIND_END) begin
                if (quoted) close_current();
                else if (minus_held) lone_token(CH_MINUS);
                else if (kept_len != 0) close_current();
                quoted     = 1'b0;
                minus_held = 1'b0;
                kept_len   = '0;
            end else begin
                take_text(req.char_code);
            end
            if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
            foreach (run[i]) owed_results.push_back(run[i]);
        endfunction

        task report(input string what);
            if (errors < 40) $display("MISMATCH: %s", what);
            errors++;
        endtask

        task check_result(input t_out_item got);
            t_out_item want;
            if (owed_results.size() == 0) begin
                report($sformatf("result %p arrived with nothing owed", got));
                return;
            end
            want = owed_results.pop_front();
            if (got.has_char !== want.has_char)
                report($sformatf("has_char %b, wanted %b", got.has_char, want.has_char));
            if (got.char_value !== want.char_value)
                report($sformatf("char_value %h, wanted %h", got.char_value, want.char_value));
            if (got.token_end !== want.token_end)
                report($sformatf("token_end %b, wanted %b", got.token_end, want.token_end));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last_of_run %b, wanted %b", got.last_of_run,
                                 want.last_of_run));
        endtask

        function int outstanding();
            return owed_results.size();
        endfunction
    endclass

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      pop   = 1'b0;
    logic      full;
    logic      empty;
    t_in_item  req_item = '0;
    t_out_item result;

    token_stream_board board;
    int idle_pct = 30;
    bit hold_req = 1'b0;
    int cycles   = 0;

    script_tokenizer dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .push     (push),
        .full     (full),
        .i_item   (req_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (result)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("script_tokenizer verification failed");
            $finish;
        end
    end

    // Results are taken at the rising edge, before the block updates its outputs.
    always @(posedge clk) begin
        if (rst_n && pop && !empty) board.check_result(result);
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Consumer side: random stalls, plus one long hold-off when asked for.
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop = 1'b0;
            end else begin
                pop = 1'b1;
                if ($urandom_range(0, 99) < idle_pct) stall_left = pick_gap();
            end
        end
    end

    function automatic t_in_item text_item(input logic [15:0] c);
        return '{kind: KIND_TEXT, char_code: c};
    endfunction

    // Offers one request and holds it until the block takes it.
    task automatic offer(input t_in_item req);
        int gap;
        @(negedge clk);
        push     = 1'b1;
        req_item = req;
        @(posedge clk);
        while (full) @(posedge clk);
        board.note_request(req);
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = pick_gap();
            repeat (gap) begin
                @(negedge clk);
                push = 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic offer_text(input string s);
        for (int i = 0; i < s.len(); i++) offer(text_item({8'h00, s[i]}));
    endtask

    task automatic offer_end();
        offer('{kind: KIND_END, char_code: 16'h0000});
    endtask

    task automatic wait_drained();
        @(negedge clk);
        push = 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
    endtask

    function automatic logic [15:0] word_char();
        if ($urandom_range(0, 3) == 0) return CH_ZERO + 16'($urandom_range(0, 9));
        return 16'h0061 + 16'($urandom_range(0, 25));
    endfunction

    // One fragment of script text, mostly well formed, sometimes noise.
    task automatic random_piece();
        case ($urandom_range(0, 9))
            0, 1, 2: repeat ($urandom_range(1, 6)) offer(text_item(word_char()));
            3: begin
                offer(text_item(CH_MINUS));
                repeat ($urandom_range(1, 3))
                    offer(text_item(CH_ZERO + 16'($urandom_range(0, 9))));
            end
            4: offer(text_item(OPS[$urandom_range(0, 10)]));
            5: offer(text_item(SEPS[$urandom_range(0, 3)]));
            6: begin
                offer(text_item(CH_QUOTE));
                repeat ($urandom_range(0, 5)) offer(text_item(16'($urandom_range(32, 126))));
                offer(text_item(CH_QUOTE));
            end
            7: offer('{kind: KIND_END, char_code: 16'($urandom)});
            8: offer(text_item(16'($urandom)));
            default: begin
                offer(text_item(CH_MINUS));
                if ($urandom_range(0, 1) == 0) offer(text_item(OPS[$urandom_range(0, 10)]));
                else offer(text_item(SEPS[$urandom_range(0, 3)]));
            end
        endcase
    endtask

    initial begin
        int taken;
        bit held_once;
        bit drained_once;
        board        = new();
        held_once    = 1'b0;
        drained_once = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: operators inside words, code extremes, held minus both ways,
        // empty and open quotes, and every way in which the end of text closes things.
        offer_text("ab=");
        offer(text_item(16'h0000));
        offer(text_item(16'hFFFF));
        offer_text(" -7-x \"\"\"q (\"");
        offer_text("+*/{}[]()\t\r\n");
        offer_text("-");
        offer_end();
        offer_text("w-");
        offer_end();
        offer_text("\"z");
        offer_end();
        offer_text("\"");
        offer_end();
        offer_end();
        offer_text("--9 -\"a\"");
        offer('{kind: KIND_END, char_code: 16'hFFFF});

        // Tokens that run past the length limit, outside and inside quotes, with no idling.
        idle_pct = 0;
        repeat (int'(MAX_TOKEN_CHARS)) offer(text_item(16'h006B));
        offer_text("k-3-z");
        offer_end();
        offer_text("\"");
        repeat (int'(MAX_TOKEN_CHARS) + 2) offer(text_item(16'h0071));
        offer_text("\"");
        wait_drained();

        // Random part.  Early on the consumer holds off while operators keep coming,
        // which fills the queue; later the producer waits for everything to drain.
        idle_pct = 35;
        taken = 0;
        while (taken < RANDOM_REQS) begin
            if (!held_once && taken >= 20) begin
                held_once = 1'b1;
                idle_pct  = 0;
                hold_req  = 1'b1;
                repeat (16) offer(text_item(OPS[$urandom_range(0, 10)]));
                taken += 16;
            end
            if (!drained_once && taken >= 60) begin
                drained_once = 1'b1;
                wait_drained();
            end
            idle_pct = (taken >= 85 && taken < 100) ? 0 : 35;
            random_piece();
            taken++;
        end
        offer_end();

        wait_drained();
        repeat (10) @(posedge clk);
        if (board.errors == 0) begin
            $display("script_tokenizer verification clean");
        end else begin
            $display("script_tokenizer verification failed");
        end
        $finish;
    end
endmodule
